// File: src/i2cm_pkg.sv
package i2cm_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int ADDR_W   = 7;
  localparam int HP_W     = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NACK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd1;

  // configuration reset values
  localparam logic [ADDR_W-1:0] DEVICE_ADDR_RST = 7'd104;
  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 8'd20;

  // tick queue between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified tick
  typedef struct packed {
    logic              cmd_go;
    logic              is_read;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [LEN_W-1:0]  len;
    logic              sda_in;
  } tick_t;

  // head of the tick queue as seen by the engine
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } queue_head_t;

endpackage

// File: src/i2cm_in_if.sv
interface i2cm_in_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] reg_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [LEN_W-1:0]  read_len;
  logic              sda_in;

  modport source (output valid, cmd, reg_addr, wr_data, read_len, sda_in, input ready);
  modport sink   (input valid, cmd, reg_addr, wr_data, read_len, sda_in, output ready);
endinterface

// File: src/i2cm_out_if.sv
interface i2cm_out_if import i2cm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                scl;
  logic                sda_release;
  logic [BYTE_W-1:0]   rd_byte;
  logic                rd_valid;
  logic                rd_last;
  logic                busy_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, scl, sda_release, rd_byte, rd_valid, rd_last, busy_res,
                  status, input ready);
  modport sink   (input valid, scl, sda_release, rd_byte, rd_valid, rd_last, busy_res,
                  status, output ready);
endinterface

// File: src/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; #(
  parameter int MAX_READ_LEN = 16
) (
  i2cm_in_if.sink in_bus,
  input  logic    q_full,
  output logic    push,
  output tick_t   tick
);

  // read length can never exceed what the field holds
  localparam int LEN_MAX_FIELD = (1 << LEN_W) - 1;
  localparam int LEN_CLIP = (MAX_READ_LEN > LEN_MAX_FIELD) ? LEN_MAX_FIELD : MAX_READ_LEN;

  logic [LEN_W-1:0] len_floor;

  // accept a beat whenever the queue has room
  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

  // zero length reads one byte, long reads are clipped
  assign len_floor = (in_bus.read_len == '0) ? LEN_W'(1) : in_bus.read_len;

  // classify the command
  always_comb begin
    tick.cmd_go   = (in_bus.cmd == CMD_READ) || (in_bus.cmd == CMD_WRITE);
    tick.is_read  = (in_bus.cmd == CMD_READ);
    tick.reg_addr = in_bus.reg_addr;
    tick.wr_data  = in_bus.wr_data;
    tick.len      = (len_floor > LEN_W'(LEN_CLIP)) ? LEN_W'(LEN_CLIP) : len_floor;
    tick.sda_in   = in_bus.sda_in;
  end

endmodule

// File: src/i2cm_queue.sv
module i2cm_queue import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tick_t       wr_tick,
  output logic        full,
  output queue_head_t head,
  input  logic        pop
);

  tick_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.tick  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_tick;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/i2cm_engine.sv
module i2cm_engine import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  queue_head_t           head,
  output logic                  pop,
  i2cm_out_if.source            out_bus
);

  // bus phases
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_RS_LOW  = 5'd1;
  localparam logic [4:0] PH_ST_HIGH = 5'd2;
  localparam logic [4:0] PH_ST_FALL = 5'd3;
  localparam logic [4:0] PH_ST_HOLD = 5'd4;
  localparam logic [4:0] PH_W_LOW   = 5'd5;
  localparam logic [4:0] PH_W_HIGH  = 5'd6;
  localparam logic [4:0] PH_AK_LOW  = 5'd7;
  localparam logic [4:0] PH_AK_HIGH = 5'd8;
  localparam logic [4:0] PH_R_LOW   = 5'd9;
  localparam logic [4:0] PH_R_HIGH  = 5'd10;
  localparam logic [4:0] PH_M_LOW   = 5'd11;
  localparam logic [4:0] PH_M_HIGH  = 5'd12;
  localparam logic [4:0] PH_P_LOW   = 5'd13;
  localparam logic [4:0] PH_P_HIGH  = 5'd14;
  localparam logic [4:0] PH_P_END   = 5'd15;
  localparam logic [4:0] PH_X_LOW   = 5'd16;
  localparam logic [4:0] PH_X_HIGH  = 5'd17;
  localparam logic [4:0] PH_X_END   = 5'd18;

  // configuration
  logic [ADDR_W-1:0] device_addr_r;
  logic [HP_W-1:0]   half_period_r;

  // transaction state
  logic [4:0]        phase_r,     phase_nxt;
  logic [HP_W-1:0]   delay_r,     delay_nxt;
  logic [2:0]        bit_cnt_r,   bit_cnt_nxt;
  logic [BYTE_W-1:0] shift_r,     shift_nxt;
  logic [LEN_W-1:0]  bytes_r,     bytes_nxt;
  logic [BYTE_W-1:0] held_reg_r,  held_reg_nxt;
  logic [BYTE_W-1:0] held_data_r, held_data_nxt;
  logic [LEN_W-1:0]  held_len_r,  held_len_nxt;
  logic              is_read_r,   is_read_nxt;

  // result register
  logic                out_valid_r;
  logic                scl_r,  scl_nxt;
  logic                rel_r,  rel_nxt;
  logic [BYTE_W-1:0]   rd_r,   rd_nxt;
  logic                rdv_r,  rdv_nxt;
  logic                rdl_r,  rdl_nxt;
  logic                busy_r, busy_nxt;
  logic [STATUS_W-1:0] st_r,   st_nxt;

  logic [HP_W-1:0] hp;
  logic            wbit;
  logic            last;

  // one tick moves whenever the result slot is free or being emptied
  assign pop  = head.valid && (!out_valid_r || out_bus.ready);
  assign hp   = (half_period_r == '0) ? HP_W'(1) : half_period_r;
  assign wbit = shift_r[BYTE_W-1];
  assign last = (bytes_r >= held_len_r);

  // bus step for one tick
  always_comb begin
    phase_nxt     = phase_r;
    delay_nxt     = delay_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    bytes_nxt     = bytes_r;
    held_reg_nxt  = held_reg_r;
    held_data_nxt = held_data_r;
    held_len_nxt  = held_len_r;
    is_read_nxt   = is_read_r;
    scl_nxt       = 1'b1;
    rel_nxt       = 1'b1;
    rd_nxt        = '0;
    rdv_nxt       = 1'b0;
    rdl_nxt       = 1'b0;
    busy_nxt      = 1'b0;
    st_nxt        = STAT_NONE;

    if (pop) begin
      // new command starts the START on this very tick
      if (phase_r == PH_IDLE && head.tick.cmd_go) begin
        held_reg_nxt  = head.tick.reg_addr;
        held_data_nxt = head.tick.wr_data;
        held_len_nxt  = head.tick.len;
        is_read_nxt   = head.tick.is_read;
        bytes_nxt     = '0;
        bit_cnt_nxt   = '0;
        shift_nxt     = '0;
        delay_nxt     = '0;
        phase_nxt     = PH_ST_HIGH;
      end

      // line levels of the current phase
      unique case (phase_nxt)
        PH_RS_LOW:  begin scl_nxt = 1'b0; rel_nxt = 1'b1; end
        PH_ST_HIGH: begin scl_nxt = 1'b1; rel_nxt = 1'b1; end
        PH_ST_FALL: begin scl_nxt = 1'b1; rel_nxt = 1'b0; end
        PH_ST_HOLD: begin scl_nxt = 1'b0; rel_nxt = 1'b0; end
        PH_W_LOW:   begin scl_nxt = 1'b0; rel_nxt = wbit; end
        PH_W_HIGH:  begin scl_nxt = 1'b1; rel_nxt = wbit; end
        PH_AK_LOW, PH_R_LOW: begin
          scl_nxt = 1'b0; rel_nxt = 1'b1;
        end
        PH_AK_HIGH, PH_R_HIGH: begin
          scl_nxt = 1'b1; rel_nxt = 1'b1;
        end
        PH_M_LOW:   begin scl_nxt = 1'b0; rel_nxt = last; end
        PH_M_HIGH:  begin scl_nxt = 1'b1; rel_nxt = last; end
        PH_P_LOW, PH_X_LOW: begin
          scl_nxt = 1'b0; rel_nxt = 1'b0;
        end
        PH_P_HIGH, PH_X_HIGH: begin
          scl_nxt = 1'b1; rel_nxt = 1'b0;
        end
        PH_P_END, PH_X_END: begin
          scl_nxt = 1'b1; rel_nxt = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE; scl_nxt = 1'b1; rel_nxt = 1'b1;
        end
      endcase

      busy_nxt = (phase_nxt != PH_IDLE);

      // half period timer and phase advance
      if (busy_nxt) begin
        if (({1'b0, delay_nxt} + 9'd1) < {1'b0, hp}) begin
          delay_nxt = delay_nxt + HP_W'(1);
        end else begin
          delay_nxt = '0;
          unique case (phase_nxt)
            PH_RS_LOW:  phase_nxt = PH_ST_HIGH;
            PH_ST_HIGH: phase_nxt = PH_ST_FALL;
            PH_ST_FALL: phase_nxt = PH_ST_HOLD;
            PH_ST_HOLD: begin
              shift_nxt   = {device_addr_r, (bytes_nxt != '0)};
              bit_cnt_nxt = '0;
              phase_nxt   = PH_W_LOW;
            end
            PH_W_LOW:   phase_nxt = PH_W_HIGH;
            PH_W_HIGH: begin
              shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
              if (bit_cnt_nxt == 3'd7) begin
                bit_cnt_nxt = '0;
                phase_nxt   = PH_AK_LOW;
              end else begin
                bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                phase_nxt   = PH_W_LOW;
              end
            end
            PH_AK_LOW:  phase_nxt = PH_AK_HIGH;
            PH_AK_HIGH: begin
              // slave nack aborts with a stop
              priority if (head.tick.sda_in) begin
                phase_nxt = PH_X_LOW;
              end else if (bytes_nxt == LEN_W'(0)) begin
                shift_nxt = held_reg_nxt;
                bytes_nxt = LEN_W'(1);
                phase_nxt = PH_W_LOW;
              end else if (bytes_nxt == LEN_W'(1)) begin
                bytes_nxt = LEN_W'(2);
                if (is_read_nxt) begin
                  phase_nxt = PH_RS_LOW;
                end else begin
                  shift_nxt = held_data_nxt;
                  phase_nxt = PH_W_LOW;
                end
              end else if (is_read_nxt) begin
                bytes_nxt   = '0;
                shift_nxt   = '0;
                bit_cnt_nxt = '0;
                phase_nxt   = PH_R_LOW;
              end else begin
                phase_nxt = PH_P_LOW;
              end
            end
            PH_R_LOW:   phase_nxt = PH_R_HIGH;
            PH_R_HIGH: begin
              shift_nxt = {shift_nxt[BYTE_W-2:0], head.tick.sda_in};
              if (bit_cnt_nxt == 3'd7) begin
                bit_cnt_nxt = '0;
                bytes_nxt   = bytes_nxt + LEN_W'(1);
                rd_nxt      = shift_nxt;
                rdv_nxt     = 1'b1;
                rdl_nxt     = (bytes_nxt >= held_len_nxt);
                phase_nxt   = PH_M_LOW;
              end else begin
                bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                phase_nxt   = PH_R_LOW;
              end
            end
            PH_M_LOW:   phase_nxt = PH_M_HIGH;
            PH_M_HIGH: begin
              shift_nxt = '0;
              phase_nxt = last ? PH_P_LOW : PH_R_LOW;
            end
            PH_P_LOW:   phase_nxt = PH_P_HIGH;
            PH_P_HIGH:  phase_nxt = PH_P_END;
            PH_P_END: begin
              st_nxt    = STAT_OK;
              phase_nxt = PH_IDLE;
            end
            PH_X_LOW:   phase_nxt = PH_X_HIGH;
            PH_X_HIGH:  phase_nxt = PH_X_END;
            PH_X_END: begin
              st_nxt    = STAT_NACK;
              phase_nxt = PH_IDLE;
            end
            default:    phase_nxt = PH_IDLE;
          endcase
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_addr_r <= DEVICE_ADDR_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEVICE_ADDR: device_addr_r <= cfg_data[ADDR_W-1:0];
        CFG_HALF_PERIOD: half_period_r <= cfg_data[HP_W-1:0];
        default: ;
      endcase
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      bytes_r     <= '0;
      held_reg_r  <= '0;
      held_data_r <= '0;
      held_len_r  <= '0;
      is_read_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      bytes_r     <= bytes_nxt;
      held_reg_r  <= held_reg_nxt;
      held_data_r <= held_data_nxt;
      held_len_r  <= held_len_nxt;
      is_read_r   <= is_read_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_bus.ready) begin
      out_valid_r <= pop;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      scl_r  <= scl_nxt;
      rel_r  <= rel_nxt;
      rd_r   <= rd_nxt;
      rdv_r  <= rdv_nxt;
      rdl_r  <= rdl_nxt;
      busy_r <= busy_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.scl         = scl_r;
  assign out_bus.sda_release = rel_r;
  assign out_bus.rd_byte     = rd_r;
  assign out_bus.rd_valid    = rdv_r;
  assign out_bus.rd_last     = rdl_r;
  assign out_bus.busy_res    = busy_r;
  assign out_bus.status      = st_r;

endmodule

// File: src/i2c_master_register_access_unit.sv
// channel | dir | handshake           | beat carries
// in_bus  | in  | valid/ready         | cmd, reg_addr, wr_data, read_len, sda_in
// out_bus | out | valid/ready         | scl, sda_release, rd_byte, rd_valid, rd_last,
//         |     |                     | busy_res, status
// cfg_*   | in  | cfg_we, no wait     | cfg_idx selects register, cfg_data
//
// one tick per cycle unless out_bus stalls; ticks pass the queue and the result register
// the engine's bus step (one state update per tick) sets the rate
// rst_n is synchronous: bus idle, queue and result slot empty, config to defaults
// a stalled out_bus fills the two-entry tick queue, then in_bus.ready drops
module i2c_master_register_access_unit import i2cm_pkg::*; #(
  parameter int MAX_READ_LEN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_in_if.sink               in_bus,
  i2cm_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        push;
  logic        q_full;
  logic        pop;
  tick_t       tick;
  queue_head_t head;

  // decode and clip incoming ticks
  i2cm_front #(
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_front (
    .in_bus (in_bus),
    .q_full (q_full),
    .push   (push),
    .tick   (tick)
  );

  // decoupling queue
  i2cm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_tick (tick),
    .full    (q_full),
    .head    (head),
    .pop     (pop)
  );

  // bus sequencer and result register
  i2cm_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .out_bus  (out_bus)
  );

endmodule

// File: src/i2cm_checker.sv
module i2cm_checker import i2cm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                scl,
  input logic                sda_release,
  input logic [BYTE_W-1:0]   rd_byte,
  input logic                rd_valid,
  input logic                rd_last,
  input logic                busy_res,
  input logic [STATUS_W-1:0] status
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // ticks taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_beat && !out_beat) begin
      pending_r <= pending_r + 3'd1;
    end else if (out_beat && !in_beat) begin
      pending_r <= pending_r - 3'd1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({scl, sda_release, rd_byte, rd_valid, rd_last, busy_res, status}))
    else $error("result changed while stalled");

  // no result without a tick behind it
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without an accepted tick");

  // queue plus result slot bound the ticks in flight
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd3)
    else $error("too many ticks in flight");

  // input only stalls when the queue really is full
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> pending_r >= 3'd2)
    else $error("input stalled with room left");

endmodule

bind i2c_master_register_access_unit i2cm_checker u_i2cm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .scl         (out_bus.scl),
  .sda_release (out_bus.sda_release),
  .rd_byte     (out_bus.rd_byte),
  .rd_valid    (out_bus.rd_valid),
  .rd_last     (out_bus.rd_last),
  .busy_res    (out_bus.busy_res),
  .status      (out_bus.status)
);
